/* src/scalar_mod_order_alu_unit_defines.svh */
// Assertion macros for the scalar mod-order ALU.
// Used by the top level only; needs clk and rst in scope.
`ifndef SCALAR_MOD_ORDER_ALU_UNIT_DEFINES_SVH
`define SCALAR_MOD_ORDER_ALU_UNIT_DEFINES_SVH

// same-cycle implication
`define SMO_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMO_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/smo_pkg.sv */
// Constants, codes and helper functions for the scalar mod-order ALU.
// No dependencies.
package smo_pkg;

  typedef logic [63:0]  limb_t;
  typedef logic [255:0] u256_t;

  localparam logic [1:0] KIND_REDUCE = 2'd0;
  localparam logic [1:0] KIND_MUL    = 2'd1;
  localparam logic [1:0] KIND_ADD    = 2'd2;
  localparam logic [1:0] KIND_INV    = 2'd3;

  localparam u256_t ORD_N =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
  localparam u256_t INV_EXP =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD036413F;
  localparam limb_t FOLD_C0 = 64'h402DA1732FC9BEBF;
  localparam limb_t FOLD_C1 = 64'h4551231950B75FC4;

  // x mod N for x below 2^257 and below 2N
  function automatic u256_t cond_sub(input logic [256:0] x);
    logic [257:0] d;
    d = {1'b0, x} - {2'b00, ORD_N};
    if (d[257]) return x[255:0];
    else return d[255:0];
  endfunction

endpackage

/* src/smo_mul64.sv */
// Shared 64x64 multiplier: one 32x32 multiplier reused for all partial products, 128-bit product.
// No dependencies.
module smo_mul64 (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p,
  output logic         done
);

  logic [63:0] la, lb;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] xa, xb;
  logic [63:0] pp;
  logic [6:0]  sh;

  // cnt 0: a0*b0, 1: a0*b1, 2: a1*b0, 3: a1*b1
  always_comb begin
    xa = cnt[1] ? la[63:32] : la[31:0];
    xb = cnt[0] ? lb[63:32] : lb[31:0];
    pp = {32'd0, xa} * {32'd0, xb};
    sh = {cnt[1] & cnt[0], cnt[1] ^ cnt[0], 5'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (start) begin
        la   <= a;
        lb   <= b;
        p    <= '0;
        cnt  <= 2'd0;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        p    <= p + ({64'd0, pp} << sh);
        cnt  <= cnt + 2'd1;
        busy <= (cnt != 2'd3);
        done <= (cnt == 2'd3);
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

/* src/scalar_mod_order_alu_unit.sv */
// Top level of the scalar mod-order ALU: sequencer, accumulator, result register.
// Depends on smo_pkg, smo_mul64 and scalar_mod_order_alu_unit_defines.svh.
//
//  channel | signals                                       | direction
//  in      | in_valid, in_stall, kind, opa_*, opb_*        | request
//  out     | out_valid, out_stall, res_limb*, zero_inverse | response
//
// One transaction at a time; in_stall is high from accept until the result is staged.
// Each 64x64 partial product: an issue state, then 4 passes on the shared multiplier.
// Fold: 1 check + 8 partial products; reduce: up to 4 folds, then the final subtract.
// Modular multiply: input reductions, setup, products, up to 4 folds, final subtract; add: reductions, one add.
// Inverse: 256 squarings plus one multiply per set exponent bit, 452 modular multiplies.
// Reset clears control only; a stalled result holds in the output register.
`include "scalar_mod_order_alu_unit_defines.svh"

module scalar_mod_order_alu_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] opa_limb0,
  input  logic [63:0] opa_limb1,
  input  logic [63:0] opa_limb2,
  input  logic [63:0] opa_limb3,
  input  logic [63:0] opb_limb0,
  input  logic [63:0] opb_limb1,
  input  logic [63:0] opb_limb2,
  input  logic [63:0] opb_limb3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] res_limb0,
  output logic [63:0] res_limb1,
  output logic [63:0] res_limb2,
  output logic [63:0] res_limb3,
  output logic        zero_inverse
);

  typedef enum logic [3:0] {
    S_IDLE, S_RED_A, S_RED_B, S_OPER, S_MMUL, S_MACC,
    S_FCHK, S_FMUL, S_FACC, S_FIN, S_DONE
  } state_t;

  state_t            state;
  logic [1:0]        op;
  smo_pkg::u256_t    opx, opy, base, hreg;
  logic [511:0]      acc;
  logic [1:0]        i, j;
  logic              ph, sq, flag;
  logic [2:0]        fcnt;
  logic [7:0]        idx;

  logic [63:0]       ma, mb;
  logic [127:0]      prod;
  logic              mul_start, mul_done;
  logic [2:0]        pos;
  logic [511:0]      acc_sum;
  smo_pkg::u256_t    fin_r;
  smo_pkg::u256_t    res_all;

  always_comb begin
    if (state == S_FMUL || state == S_FACC) begin
      ma  = hreg[{j, 6'd0} +: 64];
      mb  = ph ? smo_pkg::FOLD_C1 : smo_pkg::FOLD_C0;
      pos = {1'b0, j} + {2'b00, ph};
    end else begin
      ma  = opx[{i, 6'd0} +: 64];
      mb  = opy[{j, 6'd0} +: 64];
      pos = {1'b0, i} + {1'b0, j};
    end
  end

  assign mul_start = (state == S_MMUL) || (state == S_FMUL);

  smo_mul64 u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (ma),
    .b    (mb),
    .p    (prod),
    .done (mul_done)
  );

  assign acc_sum  = acc + ({384'd0, prod} << {pos, 6'd0});
  assign fin_r    = smo_pkg::cond_sub({1'b0, acc[255:0]});
  assign in_stall = (state != S_IDLE);
  assign res_all  = {res_limb3, res_limb2, res_limb1, res_limb0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op   <= kind;
            opx  <= {opa_limb3, opa_limb2, opa_limb1, opa_limb0};
            opy  <= {opb_limb3, opb_limb2, opb_limb1, opb_limb0};
            acc  <= {opb_limb3, opb_limb2, opb_limb1, opb_limb0,
                     opa_limb3, opa_limb2, opa_limb1, opa_limb0};
            fcnt <= 3'd0;
            flag <= 1'b0;
            state <= (kind == smo_pkg::KIND_REDUCE) ? S_FCHK : S_RED_A;
          end
        end
        S_RED_A: begin
          opx   <= smo_pkg::cond_sub({1'b0, opx});
          state <= S_RED_B;
        end
        S_RED_B: begin
          opy   <= smo_pkg::cond_sub({1'b0, opy});
          state <= S_OPER;
        end
        S_OPER: begin
          acc  <= '0;
          i    <= 2'd0;
          j    <= 2'd0;
          fcnt <= 3'd0;
          case (op)
            smo_pkg::KIND_ADD: begin
              opx   <= smo_pkg::cond_sub({1'b0, opx} + {1'b0, opy});
              state <= S_DONE;
            end
            smo_pkg::KIND_INV: begin
              if (opx == '0) begin
                flag  <= 1'b1;
                state <= S_DONE;
              end else begin
                base  <= opx;
                opx   <= 256'd1;
                opy   <= 256'd1;
                idx   <= 8'd255;
                sq    <= 1'b1;
                state <= S_MMUL;
              end
            end
            default: state <= S_MMUL;
          endcase
        end
        S_MMUL: state <= S_MACC;
        S_MACC: begin
          if (mul_done) begin
            acc <= acc_sum;
            j   <= j + 2'd1;
            if (j == 2'd3) begin
              i <= i + 2'd1;
              if (i == 2'd3) begin
                fcnt  <= 3'd0;
                state <= S_FCHK;
              end else begin
                state <= S_MMUL;
              end
            end else begin
              state <= S_MMUL;
            end
          end
        end
        S_FCHK: begin
          if (acc[511:256] == '0 || fcnt == 3'd4) begin
            state <= S_FIN;
          end else begin
            hreg  <= acc[511:256];
            acc   <= {256'd0, acc[255:0]} + ({256'd0, acc[511:256]} << 128);
            fcnt  <= fcnt + 3'd1;
            j     <= 2'd0;
            ph    <= 1'b0;
            state <= S_FMUL;
          end
        end
        S_FMUL: state <= S_FACC;
        S_FACC: begin
          if (mul_done) begin
            acc <= acc_sum;
            ph  <= ~ph;
            if (ph) begin
              j     <= j + 2'd1;
              state <= (j == 2'd3) ? S_FCHK : S_FMUL;
            end else begin
              state <= S_FMUL;
            end
          end
        end
        S_FIN: begin
          opx <= fin_r;
          if (op == smo_pkg::KIND_INV) begin
            acc <= '0;
            i   <= 2'd0;
            j   <= 2'd0;
            if (sq && smo_pkg::INV_EXP[idx]) begin
              sq    <= 1'b0;
              opy   <= base;
              state <= S_MMUL;
            end else if (idx == 8'd0) begin
              state <= S_DONE;
            end else begin
              idx   <= idx - 8'd1;
              sq    <= 1'b1;
              opy   <= fin_r;
              state <= S_MMUL;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            res_limb0    <= flag ? 64'd0 : opx[63:0];
            res_limb1    <= flag ? 64'd0 : opx[127:64];
            res_limb2    <= flag ? 64'd0 : opx[191:128];
            res_limb3    <= flag ? 64'd0 : opx[255:192];
            zero_inverse <= flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SMO_AST_NOW(a_zero_inv_res, out_valid && zero_inverse, res_all == '0, "zero inverse with nonzero result")
  `SMO_AST_NOW(a_canonical, out_valid, res_all < smo_pkg::ORD_N, "result not below N")
  `SMO_AST_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")

endmodule
